FILE: hdl/pcd_pkg.sv
// ============================================================================
// pcd_pkg: shared types and constants of the CO2 PWM duty decoder
// Status codes, configuration indexes, reset values and arithmetic constants.
// ============================================================================
package pcd_pkg;

    localparam int COUNT_WIDTH_DEF = 12;

    localparam int TIMEOUT_W = 12;
    localparam int FS_W      = 14;
    localparam int TIME_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 14;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 12'd2500;
    localparam logic [FS_W-1:0]      FS_RESET      = 14'd5000;

    // numerator = high - NUM_BIAS, divisor = high + low - DIV_BIAS
    localparam int NUM_BIAS = 2;
    localparam int DIV_BIAS = 4;

    // results strictly between SUB_LO and SUB_HI read as SUB_VAL
    localparam int SUB_LO  = 385;
    localparam int SUB_HI  = 399;
    localparam int SUB_VAL = 400;

    localparam int TIME_MAX = 4095;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_TIMEOUT = 2'd1,
        STATUS_BAD     = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT    = 1'b0,
        CFG_FULL_SCALE = 1'b1
    } cfg_idx_t;

    // saturate a count to the reported time width
    function automatic logic [TIME_W-1:0] sat_time(input logic [31:0] v);
        logic [TIME_W-1:0] r;
        r = (v > 32'(TIME_MAX)) ? TIME_W'(TIME_MAX) : v[TIME_W-1:0];
        return r;
    endfunction

endpackage

FILE: hdl/pcd_fifo.sv
// ============================================================================
// pcd_fifo: small job queue between tick front end and divider back end
// Register-based FIFO, combinational read of the head entry.
// ============================================================================
module pcd_fifo #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/pcd_front.sv
// ============================================================================
// pcd_front: tick-level pulse timer
// Tracks the PWM phase per tick, counts high and low time, emits a job at
// measurement end or timeout.
// ============================================================================
module pcd_front #(
    parameter int COUNT_WIDTH = pcd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          start_req,
    input  logic                          level,
    input  logic [pcd_pkg::TIMEOUT_W-1:0] timeout_ticks,
    output logic                          job_push,
    output logic                          job_timeout,
    output logic [COUNT_WIDTH-1:0]        job_high,
    output logic [COUNT_WIDTH-1:0]        job_low
);

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_AWAIT_LOW  = 5'b00010,
        PH_AWAIT_HIGH = 5'b00100,
        PH_TIME_HIGH  = 5'b01000,
        PH_TIME_LOW   = 5'b10000
    } phase_t;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    phase_t                 phase_reg, phase_next, eff_phase;
    logic [COUNT_WIDTH-1:0] elapsed_reg, elapsed_next, eff_elapsed;
    logic [COUNT_WIDTH-1:0] high_reg, high_next, eff_high;
    logic [COUNT_WIDTH-1:0] low_reg, low_next, eff_low;

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        job_push     = 1'b0;
        job_timeout  = 1'b0;
        eff_phase    = phase_reg;
        eff_elapsed  = elapsed_reg;
        eff_high     = high_reg;
        eff_low      = low_reg;
        if (start_req)
        begin
            eff_phase   = PH_AWAIT_LOW;
            eff_elapsed = '0;
            eff_high    = '0;
            eff_low     = '0;
        end
        job_high = eff_high;
        job_low  = eff_low;
        if (accept)
        begin
            phase_next   = eff_phase;
            elapsed_next = eff_elapsed;
            high_next    = eff_high;
            low_next     = eff_low;
            if (eff_phase == PH_IDLE)
            begin
                phase_next = PH_IDLE;
            end
            else if (32'(eff_elapsed) >= 32'(timeout_ticks))
            begin
                phase_next  = PH_IDLE;
                job_push    = 1'b1;
                job_timeout = 1'b1;
            end
            else
            begin
                elapsed_next = (eff_elapsed < CNT_MAX) ? eff_elapsed + 1'b1 : eff_elapsed;
                case (eff_phase)
                    PH_AWAIT_LOW:
                    begin
                        if (!level)
                        begin
                            phase_next = PH_AWAIT_HIGH;
                        end
                    end
                    PH_AWAIT_HIGH:
                    begin
                        if (level)
                        begin
                            high_next  = COUNT_WIDTH'(1);
                            phase_next = PH_TIME_HIGH;
                        end
                    end
                    PH_TIME_HIGH:
                    begin
                        if (level)
                        begin
                            high_next = (eff_high < CNT_MAX) ? eff_high + 1'b1 : eff_high;
                        end
                        else
                        begin
                            low_next   = COUNT_WIDTH'(1);
                            phase_next = PH_TIME_LOW;
                        end
                    end
                    PH_TIME_LOW:
                    begin
                        if (!level)
                        begin
                            low_next = (eff_low < CNT_MAX) ? eff_low + 1'b1 : eff_low;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            job_push   = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            high_reg    <= '0;
            low_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            high_reg    <= high_next;
            low_reg     <= low_next;
        end
    end

endmodule

FILE: hdl/pcd_back.sv
// ============================================================================
// pcd_back: ppm computation and output register
// One multiply, then a restoring divider retiring one quotient bit per cycle.
// ============================================================================
module pcd_back #(
    parameter int COUNT_WIDTH = pcd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_avail,
    input  logic                           job_timeout,
    input  logic [COUNT_WIDTH-1:0]         job_high,
    input  logic [COUNT_WIDTH-1:0]         job_low,
    output logic                           job_pop,
    input  logic [pcd_pkg::FS_W-1:0]       full_scale_ppm,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pcd_pkg::status_t               status,
    output logic [pcd_pkg::FS_W-1:0]       ppm,
    output logic [pcd_pkg::TIME_W-1:0]     high_time,
    output logic [pcd_pkg::TIME_W-1:0]     low_time
);

    localparam int PW   = pcd_pkg::FS_W + COUNT_WIDTH;   // product / quotient
    localparam int DW   = COUNT_WIDTH + 1;               // divisor
    localparam int CNTW = $clog2(PW + 1);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_DIV  = 4'b0100,
        B_DONE = 4'b1000
    } bstate_t;

    bstate_t                state_reg, state_next;
    logic                   tmo_reg, tmo_next;
    logic [COUNT_WIDTH-1:0] hi_reg, hi_next;
    logic [COUNT_WIDTH-1:0] lo_reg, lo_next;
    logic                   bad_reg, bad_next;
    logic [DW-1:0]          div_reg, div_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [PW-1:0]          quot_reg, quot_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;

    logic                   out_valid_reg, out_valid_next;
    pcd_pkg::status_t       status_reg, status_next;
    logic [pcd_pkg::FS_W-1:0]   ppm_reg, ppm_next;
    logic [pcd_pkg::TIME_W-1:0] high_time_reg, high_time_next;
    logic [pcd_pkg::TIME_W-1:0] low_time_reg, low_time_next;

    logic [DW-1:0]          sum;
    logic [COUNT_WIDTH-1:0] num;
    logic [DW:0]            shifted;
    logic [PW-1:0]          q_adj;
    logic                   out_free;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign ppm       = ppm_reg;
    assign high_time = high_time_reg;
    assign low_time  = low_time_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign sum      = DW'(hi_reg) + DW'(lo_reg);
    assign num      = (hi_reg > COUNT_WIDTH'(pcd_pkg::NUM_BIAS))
                      ? hi_reg - COUNT_WIDTH'(pcd_pkg::NUM_BIAS) : '0;
    assign shifted  = {rem_reg, quot_reg[PW-1]};

    always_comb
    begin
        q_adj = quot_reg;
        if (q_adj > PW'(pcd_pkg::SUB_LO) && q_adj < PW'(pcd_pkg::SUB_HI))
        begin
            q_adj = PW'(pcd_pkg::SUB_VAL);
        end
        if (q_adj > PW'(full_scale_ppm))
        begin
            q_adj = PW'(full_scale_ppm);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        tmo_next       = tmo_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        bad_next       = bad_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        job_pop        = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        ppm_next       = ppm_reg;
        high_time_next = high_time_reg;
        low_time_next  = low_time_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (job_avail)
                begin
                    job_pop    = 1'b1;
                    tmo_next   = job_timeout;
                    hi_next    = job_high;
                    lo_next    = job_low;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                bad_next  = (sum <= DW'(pcd_pkg::DIV_BIAS));
                div_next  = sum - DW'(pcd_pkg::DIV_BIAS);
                quot_next = PW'(full_scale_ppm) * PW'(num);
                rem_next  = '0;
                cnt_next  = '0;
                if (tmo_reg || (sum <= DW'(pcd_pkg::DIV_BIAS)))
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (shifted >= {1'b0, div_reg})
                begin
                    rem_next  = DW'(shifted - {1'b0, div_reg});
                    quot_next = {quot_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = shifted[DW-1:0];
                    quot_next = {quot_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(PW - 1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (tmo_reg)
                    begin
                        status_next    = pcd_pkg::STATUS_TIMEOUT;
                        ppm_next       = '0;
                        high_time_next = '0;
                        low_time_next  = '0;
                    end
                    else
                    begin
                        status_next    = bad_reg ? pcd_pkg::STATUS_BAD : pcd_pkg::STATUS_OK;
                        ppm_next       = bad_reg ? '0 : q_adj[pcd_pkg::FS_W-1:0];
                        high_time_next = pcd_pkg::sat_time(32'(hi_reg));
                        low_time_next  = pcd_pkg::sat_time(32'(lo_reg));
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmo_reg       <= tmo_next;
        hi_reg        <= hi_next;
        lo_reg        <= lo_next;
        bad_reg       <= bad_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        status_reg    <= status_next;
        ppm_reg       <= ppm_next;
        high_time_reg <= high_time_next;
        low_time_reg  <= low_time_next;
    end

endmodule

FILE: hdl/pwm_co2_ppm_decoder.sv
// ============================================================================
// pwm_co2_ppm_decoder: CO2 sensor PWM duty-cycle to ppm decoder
// Times one high pulse and the following low gap, then reports ppm.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall): one request per millisecond tick,
//   carrying start_req and the sampled pin level. A request is taken at a
//   clock edge with in_valid high and in_stall low. in_stall rises only
//   while the two-entry job queue is full.
//   Output channel (out_valid / out_stall): one request per finished or
//   timed-out measurement: status, ppm, high_time, low_time.
//   Config channel (cfg_valid / cfg_ready): cfg_index 0 = timeout_ticks,
//   1 = full_scale_ppm. cfg_ready is always high; write only while idle.
//   Path: the tick that ends a measurement is queued, then the back end
//   takes it through the multiply state, the restoring divider at one
//   quotient bit per cycle (COUNT_WIDTH + 14 bits), then the output
//   register. Timeout and bad-period results skip the divider. Ticks are
//   taken every cycle while the queue has room; the divider works on one
//   job at a time and takes the next from the queue only once the last
//   result is registered.
//   Reset: idle, no result pending, registers at 2500 ticks and 5000 ppm.
//   A stalled result holds in the output register; the divider waits behind
//   it and ticks keep flowing until the queue fills.
// ============================================================================
module pwm_co2_ppm_decoder #(
    parameter int COUNT_WIDTH = pcd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // tick input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            start_req,
    input  logic                            level,
    // result output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [pcd_pkg::FS_W-1:0]        ppm,
    output logic [pcd_pkg::TIME_W-1:0]      high_time,
    output logic [pcd_pkg::TIME_W-1:0]      low_time,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // job = {timeout flag, high count, low count}
    localparam int JOB_W = 1 + 2 * COUNT_WIDTH;

    logic [pcd_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [pcd_pkg::FS_W-1:0]      full_scale_reg;

    logic                   accept;
    logic                   job_push, job_timeout;
    logic [COUNT_WIDTH-1:0] job_high, job_low;
    logic                   fifo_full, fifo_not_empty, fifo_pop;
    logic [JOB_W-1:0]       fifo_head;
    pcd_pkg::status_t       status_int;

    assign cfg_ready = 1'b1;
    assign in_stall  = fifo_full;
    assign accept    = in_valid && !in_stall;
    assign status    = status_int;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= pcd_pkg::TIMEOUT_RESET;
            full_scale_reg <= pcd_pkg::FS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcd_pkg::CFG_TIMEOUT:    timeout_reg    <= cfg_data[pcd_pkg::TIMEOUT_W-1:0];
                pcd_pkg::CFG_FULL_SCALE: full_scale_reg <= cfg_data[pcd_pkg::FS_W-1:0];
                default:                 timeout_reg    <= timeout_reg;
            endcase
        end
    end

    // front: per-tick phase tracking and pulse counting
    pcd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .start_req     (start_req),
        .level         (level),
        .timeout_ticks (timeout_reg),
        .job_push      (job_push),
        .job_timeout   (job_timeout),
        .job_high      (job_high),
        .job_low       (job_low)
    );

    // decouples the tick stream from the divider
    pcd_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data ({job_timeout, job_high, job_low}),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .head_data (fifo_head)
    );

    // back: multiply, divide, substitute, clamp, register
    pcd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_avail      (fifo_not_empty),
        .job_timeout    (fifo_head[JOB_W-1]),
        .job_high       (fifo_head[2*COUNT_WIDTH-1:COUNT_WIDTH]),
        .job_low        (fifo_head[COUNT_WIDTH-1:0]),
        .job_pop        (fifo_pop),
        .full_scale_ppm (full_scale_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status_int),
        .ppm            (ppm),
        .high_time      (high_time),
        .low_time       (low_time)
    );

    // a job is only produced by an accepted tick, so the queue cannot overflow
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (accept && !fifo_full))
        else $error("job pushed into full queue");

    // failed measurements never carry a concentration
    a_fail_zero_ppm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_int != pcd_pkg::STATUS_OK) |-> (ppm == '0))
        else $error("nonzero ppm on failed measurement");

    // ok results stay within the configured range
    a_ppm_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_int == pcd_pkg::STATUS_OK) |-> (ppm <= full_scale_reg))
        else $error("ppm above full scale");

    // timeout results report zero times
    a_timeout_times: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_int == pcd_pkg::STATUS_TIMEOUT)
            |-> (high_time == '0 && low_time == '0))
        else $error("timeout result with nonzero times");

endmodule

FILE: tb/pcd_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// pcd_result_checker: duty-to-ppm prediction and result scoreboard
// Follows every accepted tick request and register write, predicts the
// readings the decoder must produce, and compares each accepted result
// request field by field with the oldest pending reading.
// ============================================================================
module pcd_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            start_req,
    input  logic                            level,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [1:0]                      status,
    input  logic [pcd_pkg::FS_W-1:0]        ppm,
    input  logic [pcd_pkg::TIME_W-1:0]      high_time,
    input  logic [pcd_pkg::TIME_W-1:0]      low_time,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              n_ticks,
    output int                              n_ok,
    output int                              n_timeout,
    output int                              n_bad
);

    localparam int CW = pcd_pkg::COUNT_WIDTH_DEF;

    typedef logic [CW-1:0] count_t;

    typedef enum logic [2:0] {
        MP_IDLE,
        MP_WAIT_LOW,
        MP_WAIT_HIGH,
        MP_HIGH,
        MP_LOW
    } meas_phase_t;

    typedef struct packed {
        pcd_pkg::status_t            status;
        logic [pcd_pkg::FS_W-1:0]    ppm;
        logic [pcd_pkg::TIME_W-1:0]  high_time;
        logic [pcd_pkg::TIME_W-1:0]  low_time;
    } reading_t;

    // register copies
    logic [pcd_pkg::TIMEOUT_W-1:0] timeout_cfg;
    logic [pcd_pkg::FS_W-1:0]      full_scale_cfg;

    // measurement state
    meas_phase_t meas_phase;
    count_t      elapsed;
    count_t      high_cnt;
    count_t      low_cnt;

    reading_t    readings_due[$];

    function automatic count_t bump(count_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [pcd_pkg::TIME_W-1:0] clip_time(count_t v);
        return (longint'(v) > pcd_pkg::TIME_MAX) ? pcd_pkg::TIME_W'(pcd_pkg::TIME_MAX)
                                                 : pcd_pkg::TIME_W'(v);
    endfunction

    function automatic reading_t duty_reading(count_t hi, count_t lo);
        longint   divisor;
        longint   numer;
        longint   q;
        reading_t r;
        divisor     = longint'(hi) + longint'(lo) - pcd_pkg::DIV_BIAS;
        numer       = longint'(hi) - pcd_pkg::NUM_BIAS;
        r.status    = pcd_pkg::STATUS_OK;
        r.ppm       = '0;
        r.high_time = clip_time(hi);
        r.low_time  = clip_time(lo);
        if (divisor <= 0)
        begin
            r.status = pcd_pkg::STATUS_BAD;
            return r;
        end
        q = 0;
        if (numer > 0)
            q = longint'(full_scale_cfg) * numer / divisor;
        // 400 substitution comes before the full-scale clamp
        if (q > pcd_pkg::SUB_LO && q < pcd_pkg::SUB_HI)
            q = pcd_pkg::SUB_VAL;
        if (q > longint'(full_scale_cfg))
            q = longint'(full_scale_cfg);
        r.ppm = q[pcd_pkg::FS_W-1:0];
        return r;
    endfunction

    task automatic predict_tick(input logic s, input logic lvl);
        if (s)
        begin
            meas_phase = MP_WAIT_LOW;
            elapsed    = '0;
            high_cnt   = '0;
            low_cnt    = '0;
        end
        if (meas_phase == MP_IDLE)
            return;
        if (longint'(elapsed) >= longint'(timeout_cfg))
        begin
            meas_phase = MP_IDLE;
            readings_due.push_back('{pcd_pkg::STATUS_TIMEOUT, '0, '0, '0});
            return;
        end
        elapsed = bump(elapsed);
        case (meas_phase)
            MP_WAIT_LOW:  if (!lvl) meas_phase = MP_WAIT_HIGH;
            MP_WAIT_HIGH:
                if (lvl)
                begin
                    high_cnt   = count_t'(1);
                    meas_phase = MP_HIGH;
                end
            MP_HIGH:
                if (lvl)
                    high_cnt = bump(high_cnt);
                else
                begin
                    low_cnt    = count_t'(1);
                    meas_phase = MP_LOW;
                end
            MP_LOW:
                if (!lvl)
                    low_cnt = bump(low_cnt);
                else
                begin
                    meas_phase = MP_IDLE;
                    readings_due.push_back(duty_reading(high_cnt, low_cnt));
                end
            default: meas_phase = MP_IDLE;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t got;
        reading_t want;
        if (!rst_n)
        begin
            timeout_cfg    = pcd_pkg::TIMEOUT_RESET;
            full_scale_cfg = pcd_pkg::FS_RESET;
            meas_phase     = MP_IDLE;
            elapsed        = '0;
            high_cnt       = '0;
            low_cnt        = '0;
            readings_due.delete();
            fail_count     = 0;
            n_ticks        = 0;
            n_ok           = 0;
            n_timeout      = 0;
            n_bad          = 0;
        end
        else
        begin
            // results first: a result never stems from a tick taken this edge
            if (out_valid && !out_stall)
            begin
                got = '{pcd_pkg::status_t'(status), ppm, high_time, low_time};
                if (readings_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result status %0d ppm %0d high %0d low %0d",
                                 $time, got.status, got.ppm, got.high_time, got.low_time);
                end
                else
                begin
                    want = readings_due.pop_front();
                    case (want.status)
                        pcd_pkg::STATUS_OK:      n_ok++;
                        pcd_pkg::STATUS_TIMEOUT: n_timeout++;
                        default:                 n_bad++;
                    endcase
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch, expected status %0d ppm %0d high %0d ",
                                      "low %0d, got status %0d ppm %0d high %0d low %0d"},
                                     $time, want.status, want.ppm, want.high_time,
                                     want.low_time, got.status, got.ppm, got.high_time,
                                     got.low_time);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (pcd_pkg::cfg_idx_t'(cfg_index))
                    pcd_pkg::CFG_TIMEOUT:
                        timeout_cfg    = cfg_data[pcd_pkg::TIMEOUT_W-1:0];
                    pcd_pkg::CFG_FULL_SCALE:
                        full_scale_cfg = cfg_data[pcd_pkg::FS_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                n_ticks++;
                predict_tick(start_req, level);
            end
        end
        pending = readings_due.size();
    end

endmodule

FILE: tb/pwm_co2_ppm_decoder_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// pwm_co2_ppm_decoder_tb: top-level bench of the CO2 PWM duty decoder
// Feeds millisecond tick requests that form PWM measurements (clean pulses,
// aborted and restarted ones, noise) under several register settings and
// idling patterns; a checker beside the block predicts and scores results.
// ============================================================================
module pwm_co2_ppm_decoder_tb;

    // Run bound: ~900 ticks; even if every tick caused a result that waited
    // out a long stall plus the divider, the run stays far below this.
    localparam int CYCLE_LIMIT  = 2_000_000;
    // Quiet time after the last reading, sized for the divider path plus
    // queue occupancy.
    localparam int SETTLE_CYCLES = 80;
    // Long output hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES   = 400;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           start_req = 1'b0;
    logic                           level     = 1'b0;
    logic                           out_stall = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [pcd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pcd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                           in_stall;
    logic                           out_valid;
    logic                           cfg_ready;
    logic [1:0]                     status;
    logic [pcd_pkg::FS_W-1:0]       ppm;
    logic [pcd_pkg::TIME_W-1:0]     high_time;
    logic [pcd_pkg::TIME_W-1:0]     low_time;

    int fail_count;
    int pending_readings;
    int n_ticks;
    int n_ok;
    int n_timeout;
    int n_bad;

    // idling knobs, percent of cycles
    int in_idle_pct    = 0;
    int out_stall_pct  = 0;
    // hold-off requests: stimulus bumps hold_asked, the stall process serves it
    int hold_asked     = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    int ticks_sent     = 0;
    int cfg_writes     = 0;
    int cycle_count    = 0;

    always #5 clk = ~clk;

    pwm_co2_ppm_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_req (start_req),
        .level     (level),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ppm       (ppm),
        .high_time (high_time),
        .low_time  (low_time),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pcd_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_req  (start_req),
        .level      (level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .ppm        (ppm),
        .high_time  (high_time),
        .low_time   (low_time),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending_readings),
        .n_ticks    (n_ticks),
        .n_ok       (n_ok),
        .n_timeout  (n_timeout),
        .n_bad      (n_bad)
    );

    // Result-side stall. A pending hold-off request wins over random stalls
    // and keeps the output blocked until its hold-off counter runs down.
    always @(negedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_asked;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d readings outstanding",
                     cycle_count, pending_readings);
            $display("FAIL pwm_co2_ppm_decoder");
            $finish;
        end
    end

    // One tick request. Entered and left at a falling edge; random idle
    // cycles go in front of the request per in_idle_pct.
    task automatic send_tick(input logic s, input logic lvl);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= s;
        level     <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_tick(1'b0, lvl);
    endtask

    // A clean measurement: start (optionally while the pin is still high),
    // low level to arm, hi ticks high, lo ticks low, then the rising tick
    // that closes the gap.
    task automatic measurement(input int pre_hi, input int arm, input int hi,
                               input int lo);
        if (pre_hi > 0)
        begin
            send_tick(1'b1, 1'b1);
            send_run(1'b1, pre_hi - 1);
            send_run(1'b0, arm);
        end
        else
        begin
            send_tick(1'b1, 1'b0);
            send_run(1'b0, arm - 1);
        end
        send_run(1'b1, hi);
        send_run(1'b0, lo);
        send_tick(1'b0, 1'b1);
    endtask

    // Drop valid, wait for every predicted reading, then let the block go
    // quiet (a tick that yields nothing may still be in flight).
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_readings != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers while the block is idle.
    task automatic configure(input int tmo, input int fs);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= pcd_pkg::CFG_TIMEOUT;
        cfg_data  <= pcd_pkg::CFG_DATA_W'(tmo);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_index <= pcd_pkg::CFG_FULL_SCALE;
        cfg_data  <= pcd_pkg::CFG_DATA_W'(fs);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid  <= 1'b0;
        cfg_writes += 2;
    endtask

    function automatic int pulse_len();
        return ($urandom_range(9) < 8) ? $urandom_range(1, 10) : $urandom_range(1, 40);
    endfunction

    // Mostly well-formed measurements with random lengths; the rest are
    // aborted measurements (the next start restarts them) and raw noise.
    task automatic random_ticks(input int n_items);
        int stop_at;
        int pick;
        stop_at = ticks_sent + n_items;
        while (ticks_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                measurement(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0,
                            $urandom_range(1, 4), pulse_len(), pulse_len());
            end
            else if (pick < 88)
            begin
                send_tick(1'b1, 1'($urandom_range(1)));
                repeat ($urandom_range(0, 6)) send_tick(1'b0, 1'($urandom_range(1)));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_tick($urandom_range(9) == 0, 1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed, reset register values (2500 ticks, 5000 ppm) ----
        send_tick(1'b0, 1'b1);              // idle ticks: no reading
        send_tick(1'b0, 1'b0);
        measurement(0, 1, 1, 1);            // divisor negative: bad period
        measurement(0, 1, 2, 2);            // divisor zero: bad period
        measurement(0, 1, 1, 4);            // numerator negative: ppm 0
        measurement(0, 1, 5, 1);            // quotient above full scale
        send_tick(1'b1, 1'b0);              // start a measurement and let it run high,
        send_tick(1'b0, 1'b1);              // then restart it with the pin high
        measurement(2, 1, 3, 3);

        // zero timeout: the start tick itself times out
        configure(0, 1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);

        // 400 substitution, then substitution followed by the clamp
        configure(4095, 790);
        measurement(0, 1, 3, 3);
        configure(4095, 260);
        measurement(0, 1, 5, 1);

        // longer pulses; the last one outlasts its timeout
        configure(4095, 10000);
        measurement(0, 1, 60, 20);
        measurement(0, 1, 20, 55);
        configure(50, 10000);
        measurement(0, 1, 60, 10);

        // ---- random phases ----
        // sender idling; midway the sender waits out every pending reading
        configure(40, 10000);
        in_idle_pct = 63;
        random_ticks(50);
        settle();
        random_ticks(50);

        // receiver stalling, random registers
        configure($urandom_range(8, 80), $urandom_range(1, 10000));
        in_idle_pct   = 0;
        out_stall_pct = 63;
        random_ticks(100);

        // both sides idle; long output hold-off backs the block up
        configure(25, 1);
        in_idle_pct   = 23;
        out_stall_pct = 23;
        hold_asked   <= hold_asked + 1;
        random_ticks(100);

        // timeout of one tick: nearly everything times out
        configure(1, $urandom_range(1, 10000));
        in_idle_pct   = 0;
        out_stall_pct = 0;
        random_ticks(40);

        // widest timeout, no idling, another hold-off
        configure(4095, $urandom_range(1, 10000));
        hold_asked <= hold_asked + 1;
        random_ticks(90);

        // back to the reset values, receiver stalling once more
        configure(2500, 5000);
        out_stall_pct = 63;
        random_ticks(50);

        settle();

        $display("Run covered %0d ticks, %0d readings (%0d ok, %0d timeout, %0d bad period),",
                 n_ticks, n_ok + n_timeout + n_bad, n_ok, n_timeout, n_bad);
        $display("%0d register writes, %0d failures.", cfg_writes, fail_count);
        if (fail_count == 0 && pending_readings == 0)
            $display("PASS pwm_co2_ppm_decoder");
        else
            $display("FAIL pwm_co2_ppm_decoder");
        $finish;
    end

endmodule

FILE: files.f
hdl/pcd_pkg.sv
hdl/pcd_fifo.sv
hdl/pcd_front.sv
hdl/pcd_back.sv
hdl/pwm_co2_ppm_decoder.sv
tb/pcd_result_checker.sv
tb/pwm_co2_ppm_decoder_tb.sv
